### hw/rtl/hll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hll_pkg
// Shared types, hash constants and action codes for the HyperLogLog update.
// ----------------------------------------------------------------------------
package hll_pkg;

    localparam int PRECISION_DEFAULT = 14;
    localparam int HASH_W            = 64;
    localparam int COUNT_W           = 48;
    localparam int RANK_W            = 6;
    localparam int IDX_OUT_W         = 14;

    typedef logic [HASH_W-1:0]    t_hash;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [RANK_W-1:0]    t_rank;
    typedef logic [IDX_OUT_W-1:0] t_idx_out;
    typedef logic [1:0]           t_action;

    localparam t_action ACT_ADD_WORD    = 2'd0;
    localparam t_action ACT_STRING_BYTE = 2'd1;
    localparam t_action ACT_MERGE_RANK  = 2'd2;
    localparam t_action ACT_READ_REG    = 2'd3;

    localparam t_hash MIX_ADD   = 64'h9E3779B97F4A7C15;
    localparam t_hash MIX_MUL_A = 64'hBF58476D1CE4E5B9;
    localparam t_hash MIX_MUL_B = 64'h94D049BB133111EB;
    localparam int    MIX_SH_A  = 30;
    localparam int    MIX_SH_B  = 27;
    localparam int    MIX_SH_C  = 31;

    // FNV-1a 64: prime is 2^40 + 0x1B3
    localparam t_hash      FNV_BASIS    = 64'd14695981039346656037;
    localparam int         FNV_PRIME_SH = 40;
    localparam logic [8:0] FNV_PRIME_LO = 9'h1B3;

    // leading zeros of a nonzero byte
    function automatic logic [2:0] lz8(input logic [7:0] x);
        logic [2:0] f;
        f = 3'd7;
        for (int i = 0; i < 8; i++) begin
            if (x[i]) begin
                f = 3'(7 - i);
            end
        end
        return f;
    endfunction

endpackage

### hw/rtl/hyperloglog_sketch_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hyperloglog_sketch_update
// HyperLogLog register file update with splitmix64 and FNV-1a hashing.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / o_in_ready and each produces exactly one
//   result on o_out_valid / i_out_ready. One request is worked at a time.
//   add_word: the request passes PRE, two multiply rounds, LZ1 and LZ2 to WR; the
//   next request is taken in the cycle after the result is loaded. The mixer runs
//   two 64-bit multiplies on one shared 32x32 multiplier, each in partial products,
//   then a leading-zero count in LZ1 and LZ2 and a read-modify-write of the
//   sketch memory. A string byte marked last passes the FNV step first.
//   A string byte not marked last only updates the FNV hash. merge_rank reads
//   the memory, then compares and writes back; read_register only reads it.
//   After reset the sketch memory is cleared one entry per cycle; o_in_ready
//   stays low until all 2^PRECISION_BITS entries are cleared.
//   The result sits in an output register; a new request is accepted while
//   it waits, and the block holds before writing the memory until the
//   output register is free, so a stalled receiver just stops the pipeline.
// ----------------------------------------------------------------------------
module hyperloglog_sketch_update #(
    parameter int PRECISION_BITS = hll_pkg::PRECISION_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  hll_pkg::t_action      i_action,
    input  logic [63:0]           i_data_word,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_byte_valid,
    input  logic                  i_last_byte,
    input  logic [13:0]           i_reg_index,
    input  logic [5:0]            i_rank_in,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [63:0]           o_hash_value,
    output logic [13:0]           o_register_index,
    output logic [5:0]            o_rank,
    output logic [5:0]            o_register_value,
    output logic                  o_changed,
    output logic                  o_added,
    output logic [47:0]           o_added_count
);
    import hll_pkg::*;

    localparam int IDX_W = PRECISION_BITS;
    localparam int DEPTH = 1 << PRECISION_BITS;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_FNV  = 4'd2;
    localparam logic [3:0] S_PRE  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_POST = 4'd5;
    localparam logic [3:0] S_LZ1  = 4'd6;
    localparam logic [3:0] S_LZ2  = 4'd7;
    localparam logic [3:0] S_WR   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    // control
    logic [3:0]       r_state;
    logic [IDX_W-1:0] r_clr_addr;
    logic [1:0]       r_mcnt;
    logic             r_round;
    t_hash            r_fnv;
    t_count           r_count;
    logic             r_o_valid;

    // payload
    t_action          r_action;
    logic [7:0]       r_byte;
    logic             r_byte_valid;
    logic             r_last;
    logic             r_is_add;
    t_hash            r_src;
    t_hash            r_x;
    t_hash            r_acc;
    t_hash            r_hash;
    logic [IDX_W-1:0] r_idx;
    t_rank            r_rank_in;
    t_rank            r_rank;
    logic [7:0]       r_nz;
    logic [2:0]       r_blz [8];
    t_rank            r_rd_data;
    t_rank            r_mem [DEPTH];

    t_hash            r_o_hash;
    t_idx_out         r_o_idx;
    t_rank            r_o_rank;
    t_rank            r_o_val;
    logic             r_o_changed;
    logic             r_o_added;
    t_count           r_o_count;

    logic             in_acc;
    logic             can_out;
    t_hash            n_fnv;
    t_hash            fnv_t;
    t_hash            pre_s;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      mul_p;
    t_hash            mul_k;
    t_hash            rest;
    logic [6:0]       lz;
    t_rank            wr_rank;
    logic             raise;
    t_rank            new_val;
    t_count           n_count;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_rank            mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_done;
    logic             out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign can_out    = !r_o_valid || i_out_ready;

    // FNV-1a step: (h ^ b) * (2^40 + 0x1B3)
    assign fnv_t = r_byte_valid ? (r_fnv ^ {56'd0, r_byte}) : r_fnv;
    assign n_fnv = r_byte_valid
                 ? ((fnv_t << FNV_PRIME_SH) + (fnv_t * {55'd0, FNV_PRIME_LO}))
                 : r_fnv;

    assign pre_s = r_src + MIX_ADD;

    // low 64 bits of x*K: xL*KL + ((xL*KH + xH*KL) << 32), one term a cycle
    assign mul_k = r_round ? MIX_MUL_B : MIX_MUL_A;
    assign mul_a = (r_mcnt == 2'd2) ? r_x[63:32] : r_x[31:0];
    assign mul_b = (r_mcnt == 2'd1) ? mul_k[63:32] : mul_k[31:0];
    assign mul_p = mul_a * mul_b;

    // rank word: hash bits below the index, followed by a sentinel one
    assign rest = {r_hash[HASH_W-1-IDX_W:0], 1'b1, {(IDX_W-1){1'b0}}};

    always_comb begin
        lz = 7'd0;
        for (int b = 0; b < 8; b++) begin
            if (r_nz[b]) begin
                lz = 7'((7 - b) * 8) + {4'd0, r_blz[b]};
            end
        end
    end

    // read-modify-write
    assign wr_rank = r_is_add ? r_rank : r_rank_in;
    assign raise   = (r_action != ACT_READ_REG) && (r_rd_data < wr_rank);
    assign new_val = raise ? wr_rank : r_rd_data;
    assign n_count = (r_is_add && (r_count != {COUNT_W{1'b1}})) ? r_count + 1'b1 : r_count;
    assign wr_done = (r_state == S_WR) && can_out;
    assign out_load = wr_done || ((r_state == S_OUT) && can_out);

    assign mem_we    = (r_state == S_CLR) || (wr_done && raise);
    assign mem_waddr = (r_state == S_CLR) ? r_clr_addr : r_idx;
    assign mem_wdata = (r_state == S_CLR) ? '0 : new_val;
    assign mem_re    = in_acc || (r_state == S_LZ2);
    assign rd_addr   = (r_state == S_IDLE) ? IDX_W'(i_reg_index) : r_idx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_mcnt     <= '0;
            r_round    <= 1'b0;
            r_fnv      <= FNV_BASIS;
            r_count    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == {IDX_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_action)
                            ACT_ADD_WORD:    r_state <= S_PRE;
                            ACT_STRING_BYTE: r_state <= S_FNV;
                            default:         r_state <= S_WR;
                        endcase
                    end
                end
                S_FNV: begin
                    if (r_last) begin
                        r_fnv   <= FNV_BASIS;
                        r_state <= S_PRE;
                    end else begin
                        r_fnv   <= n_fnv;
                        r_state <= S_OUT;
                    end
                end
                S_PRE: begin
                    r_round <= 1'b0;
                    r_mcnt  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == 2'd2) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    r_mcnt <= '0;
                    if (!r_round) begin
                        r_round <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_LZ1;
                    end
                end
                S_LZ1: r_state <= S_LZ2;
                S_LZ2: r_state <= S_WR;
                S_WR: begin
                    if (can_out) begin
                        r_count   <= n_count;
                        r_state   <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (can_out) begin
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action     <= i_action;
            r_byte       <= i_data_byte;
            r_byte_valid <= i_byte_valid;
            r_last       <= i_last_byte;
            r_idx        <= IDX_W'(i_reg_index);
            r_rank_in    <= i_rank_in;
            r_src        <= i_data_word;
            r_is_add     <= (i_action == ACT_ADD_WORD);
        end
        if (r_state == S_FNV) begin
            r_src    <= n_fnv;
            r_is_add <= r_last;
        end
        if (r_state == S_PRE) begin
            r_x <= pre_s ^ (pre_s >> MIX_SH_A);
        end
        if (r_state == S_MUL) begin
            if (r_mcnt == 2'd0) begin
                r_acc <= mul_p;
            end else begin
                r_acc <= r_acc + {mul_p[31:0], 32'd0};
            end
        end
        if (r_state == S_POST) begin
            if (!r_round) begin
                r_x <= r_acc ^ (r_acc >> MIX_SH_B);
            end else begin
                r_hash <= r_acc ^ (r_acc >> MIX_SH_C);
            end
        end
        if (r_state == S_LZ1) begin
            r_idx <= r_hash[HASH_W-1 -: IDX_W];
            for (int b = 0; b < 8; b++) begin
                r_nz[b]  <= |rest[b*8 +: 8];
                r_blz[b] <= lz8(rest[b*8 +: 8]);
            end
        end
        if (r_state == S_LZ2) begin
            r_rank <= RANK_W'(lz + 7'd1);
        end
        if (wr_done) begin
            r_o_hash    <= r_is_add ? r_hash : '0;
            r_o_idx     <= IDX_OUT_W'(r_idx);
            r_o_rank    <= (r_action == ACT_READ_REG) ? '0 : wr_rank;
            r_o_val     <= new_val;
            r_o_changed <= raise;
            r_o_added   <= r_is_add;
            r_o_count   <= n_count;
        end
        if ((r_state == S_OUT) && can_out) begin
            r_o_hash    <= '0;
            r_o_idx     <= '0;
            r_o_rank    <= '0;
            r_o_val     <= '0;
            r_o_changed <= 1'b0;
            r_o_added   <= 1'b0;
            r_o_count   <= r_count;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_hash_value     = r_o_hash;
    assign o_register_index = r_o_idx;
    assign o_rank           = r_o_rank;
    assign o_register_value = r_o_val;
    assign o_changed        = r_o_changed;
    assign o_added          = r_o_added;
    assign o_added_count    = r_o_count;

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("added counter went backwards");

    a_changed_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_changed) |-> (o_register_value == o_rank))
        else $error("raised register does not hold the rank");

    a_added_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_added) |-> (o_register_value >= o_rank && o_rank != '0))
        else $error("added value left register below its rank");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |=> !o_out_valid)
        else $error("result produced during memory clear");

endmodule
